// ===== sv/rndr_pkg.sv =====
// shared types and constants for the radix number dot-matrix renderer
// used by the front classifier, the job queue, the back pipeline and the top level
package rndr_pkg;

    typedef enum logic {
        OP_VALUE = 1'b0,
        OP_GLYPH = 1'b1
    } t_op;

    localparam int CODE_W  = 5;
    localparam int BASE_W  = 5;
    localparam int MAG_W   = 16;
    localparam int FRAME_W = 96;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code GLYPH_MINUS = t_code'(16);

    // one classified item waiting for the back end
    typedef struct packed {
        t_op                    op;
        logic                   neg;
        logic [BASE_W-1:0]      base;
        logic [MAG_W-1:0]       mag;
        logic [3:0][CODE_W-1:0] codes;
    } t_job;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== sv/rndr_front.sv =====
// front end: takes an input transfer, clamps base, value and glyph codes
// depends on rndr_pkg; writes classified jobs into rndr_queue
module rndr_front import rndr_pkg::*; (
    input  logic              i_in_valid,
    input  logic              i_in_user,    // operation
    input  logic [63:0]       i_in_data,    // value, glyph0, glyph1, glyph2, glyph3
    output logic              o_in_ready,
    input  logic [BASE_W-1:0] i_number_base,
    input  logic              i_queue_full,
    output logic              o_push,
    output t_job              o_job
);

    // base^3 - 1 and base^4 - 1, indexed by the clamped base
    localparam logic [11:0] LIM3 [17] = '{
        12'd7, 12'd7, 12'd7, 12'd26, 12'd63, 12'd124, 12'd215, 12'd342, 12'd511,
        12'd728, 12'd999, 12'd1330, 12'd1727, 12'd2196, 12'd2743, 12'd3374, 12'd4095
    };
    localparam logic [15:0] LIM4 [17] = '{
        16'd15, 16'd15, 16'd15, 16'd80, 16'd255, 16'd624, 16'd1295, 16'd2400, 16'd4095,
        16'd6560, 16'd9999, 16'd14640, 16'd20735, 16'd28560, 16'd38415, 16'd50624,
        16'd65535
    };
    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    logic [BASE_W-1:0] base_c;
    logic [31:0]       value;
    logic [11:0]       lim3;
    logic [15:0]       lim4;
    logic [32:0]       low_sum;
    logic [31:0]       neg_value;
    logic [7:0]        glyph [4];

    always_comb begin
        value = i_in_data[31:0];
        for (int k = 0; k < 4; k++) begin
            glyph[k] = i_in_data[32 + 8*k +: 8];
        end

        if (i_number_base < BASE_MIN) begin
            base_c = BASE_MIN;
        end else if (i_number_base > BASE_MAX) begin
            base_c = BASE_MAX;
        end else begin
            base_c = i_number_base;
        end
        lim3 = LIM3[base_c];
        lim4 = LIM4[base_c];

        // negative side: value + (base^3 - 1) below zero means clamp
        low_sum   = {value[31], value} + {21'd0, lim3};
        neg_value = 32'd0 - value;

        o_job      = '0;
        o_job.op   = t_op'(i_in_user);
        o_job.base = base_c;
        o_job.neg  = value[31];
        if (value[31]) begin
            if (low_sum[32]) begin
                o_job.mag = {4'd0, lim3};
            end else begin
                o_job.mag = neg_value[MAG_W-1:0];
            end
        end else if (value[30:0] > {15'd0, lim4}) begin
            o_job.mag = lim4;
        end else begin
            o_job.mag = value[MAG_W-1:0];
        end

        for (int k = 0; k < 4; k++) begin
            o_job.codes[k] = (glyph[k] > 8'd16) ? GLYPH_MINUS : glyph[k][CODE_W-1:0];
        end

        o_in_ready = !i_queue_full;
        o_push     = i_in_valid && !i_queue_full;
    end

endmodule

// ===== sv/rndr_queue.sv =====
// short job queue between the front end and the back pipeline
// depends on rndr_pkg for the job type and depth
module rndr_queue import rndr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid
);

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;
    logic              do_push;
    logic              do_pop;

    always_comb begin
        o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_job   = r_mem[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== sv/rndr_back.sv =====
// back pipeline: radix digits by reciprocal multiply, then glyph drawing
// depends on rndr_pkg; pops jobs from rndr_queue, holds the output register
module rndr_back import rndr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_frame_valid,
    input  logic               i_frame_ready
);

    // ceil(2^32 / d) gives exact quotients for 16-bit dividends and d <= 4096
    localparam logic [63:0] K32 = 64'h1_0000_0000;
    localparam logic [31:0] RECIP1 [17] = '{
        32'((K32 - 64'd1) / 64'd2 + 64'd1),  32'((K32 - 64'd1) / 64'd2 + 64'd1),
        32'((K32 - 64'd1) / 64'd2 + 64'd1),  32'((K32 - 64'd1) / 64'd3 + 64'd1),
        32'((K32 - 64'd1) / 64'd4 + 64'd1),  32'((K32 - 64'd1) / 64'd5 + 64'd1),
        32'((K32 - 64'd1) / 64'd6 + 64'd1),  32'((K32 - 64'd1) / 64'd7 + 64'd1),
        32'((K32 - 64'd1) / 64'd8 + 64'd1),  32'((K32 - 64'd1) / 64'd9 + 64'd1),
        32'((K32 - 64'd1) / 64'd10 + 64'd1), 32'((K32 - 64'd1) / 64'd11 + 64'd1),
        32'((K32 - 64'd1) / 64'd12 + 64'd1), 32'((K32 - 64'd1) / 64'd13 + 64'd1),
        32'((K32 - 64'd1) / 64'd14 + 64'd1), 32'((K32 - 64'd1) / 64'd15 + 64'd1),
        32'((K32 - 64'd1) / 64'd16 + 64'd1)
    };
    localparam logic [31:0] RECIP2 [17] = '{
        32'((K32 - 64'd1) / 64'd4 + 64'd1),   32'((K32 - 64'd1) / 64'd4 + 64'd1),
        32'((K32 - 64'd1) / 64'd4 + 64'd1),   32'((K32 - 64'd1) / 64'd9 + 64'd1),
        32'((K32 - 64'd1) / 64'd16 + 64'd1),  32'((K32 - 64'd1) / 64'd25 + 64'd1),
        32'((K32 - 64'd1) / 64'd36 + 64'd1),  32'((K32 - 64'd1) / 64'd49 + 64'd1),
        32'((K32 - 64'd1) / 64'd64 + 64'd1),  32'((K32 - 64'd1) / 64'd81 + 64'd1),
        32'((K32 - 64'd1) / 64'd100 + 64'd1), 32'((K32 - 64'd1) / 64'd121 + 64'd1),
        32'((K32 - 64'd1) / 64'd144 + 64'd1), 32'((K32 - 64'd1) / 64'd169 + 64'd1),
        32'((K32 - 64'd1) / 64'd196 + 64'd1), 32'((K32 - 64'd1) / 64'd225 + 64'd1),
        32'((K32 - 64'd1) / 64'd256 + 64'd1)
    };
    localparam logic [31:0] RECIP3 [17] = '{
        32'((K32 - 64'd1) / 64'd8 + 64'd1),    32'((K32 - 64'd1) / 64'd8 + 64'd1),
        32'((K32 - 64'd1) / 64'd8 + 64'd1),    32'((K32 - 64'd1) / 64'd27 + 64'd1),
        32'((K32 - 64'd1) / 64'd64 + 64'd1),   32'((K32 - 64'd1) / 64'd125 + 64'd1),
        32'((K32 - 64'd1) / 64'd216 + 64'd1),  32'((K32 - 64'd1) / 64'd343 + 64'd1),
        32'((K32 - 64'd1) / 64'd512 + 64'd1),  32'((K32 - 64'd1) / 64'd729 + 64'd1),
        32'((K32 - 64'd1) / 64'd1000 + 64'd1), 32'((K32 - 64'd1) / 64'd1331 + 64'd1),
        32'((K32 - 64'd1) / 64'd1728 + 64'd1), 32'((K32 - 64'd1) / 64'd2197 + 64'd1),
        32'((K32 - 64'd1) / 64'd2744 + 64'd1), 32'((K32 - 64'd1) / 64'd3375 + 64'd1),
        32'((K32 - 64'd1) / 64'd4096 + 64'd1)
    };

    // five 3-bit rows, top row in the high bits, leftmost pixel in the row msb
    function automatic logic [14:0] glyph_bits(input t_code code);
        logic [14:0] g;
        case (code)
            5'd0:    g = 15'b111_101_101_101_111;
            5'd1:    g = 15'b010_110_010_010_111;
            5'd2:    g = 15'b111_001_111_100_111;
            5'd3:    g = 15'b111_001_111_001_111;
            5'd4:    g = 15'b101_101_111_001_001;
            5'd5:    g = 15'b111_100_111_001_111;
            5'd6:    g = 15'b111_100_111_101_111;
            5'd7:    g = 15'b111_001_001_001_001;
            5'd8:    g = 15'b111_101_111_101_111;
            5'd9:    g = 15'b111_101_111_001_111;
            5'd10:   g = 15'b010_101_111_101_101;
            5'd11:   g = 15'b110_101_110_101_110;
            5'd12:   g = 15'b111_100_100_100_111;
            5'd13:   g = 15'b110_001_001_001_110;
            5'd14:   g = 15'b111_100_111_100_111;
            5'd15:   g = 15'b111_100_111_100_100;
            default: g = 15'b000_000_111_000_000;
        endcase
        return g;
    endfunction

    // pixel (r,c) has index r*12+c and sits at frame bit 95-index
    function automatic logic [FRAME_W-1:0] render(input logic [3:0][CODE_W-1:0] codes);
        logic [FRAME_W-1:0] f;
        logic [14:0]        g;
        f = '0;
        for (int k = 0; k < 4; k++) begin
            g = glyph_bits(codes[k]);
            for (int r = 0; r < 5; r++) begin
                for (int j = 0; j < 3; j++) begin
                    f[FRAME_W - 1 - (r*12 + k*3 + j)] = g[14 - 3*r - j];
                end
            end
        end
        return f;
    endfunction

    // stage 1: quotients by base, base^2, base^3
    logic                   r_v1;
    t_job                   r_job1;
    logic [MAG_W-1:0]       r_q1;
    logic [MAG_W-1:0]       r_q2;
    logic [MAG_W-1:0]       r_q3;
    // stage 2: glyph codes
    logic                   r_v2;
    logic [3:0][CODE_W-1:0] r_codes2;
    // stage 3: output register
    logic                   r_v3;
    logic [FRAME_W-1:0]     r_frame;

    logic                   ready1;
    logic                   ready2;
    logic                   ready3;
    logic [47:0]            n_p1;
    logic [47:0]            n_p2;
    logic [47:0]            n_p3;
    logic [20:0]            t1;
    logic [20:0]            t2;
    logic [20:0]            t3;
    logic [MAG_W-1:0]       d3;
    logic [MAG_W-1:0]       d2;
    logic [MAG_W-1:0]       d1;
    logic [3:0][CODE_W-1:0] n_codes2;

    always_comb begin
        ready3    = !r_v3 || i_frame_ready;
        ready2    = !r_v2 || ready3;
        ready1    = !r_v1 || ready2;
        o_job_pop = ready1 && i_job_valid;

        n_p1 = 48'(i_job.mag) * 48'(RECIP1[i_job.base]);
        n_p2 = 48'(i_job.mag) * 48'(RECIP2[i_job.base]);
        n_p3 = 48'(i_job.mag) * 48'(RECIP3[i_job.base]);

        // each digit is one quotient minus the next one times the base
        t1 = 21'(r_q1) * 21'(r_job1.base);
        t2 = 21'(r_q2) * 21'(r_job1.base);
        t3 = 21'(r_q3) * 21'(r_job1.base);
        d3 = r_job1.mag - t1[MAG_W-1:0];
        d2 = r_q1 - t2[MAG_W-1:0];
        d1 = r_q2 - t3[MAG_W-1:0];

        case (r_job1.op)
            OP_GLYPH: n_codes2 = r_job1.codes;
            default: begin
                n_codes2[3] = {1'b0, d3[3:0]};
                n_codes2[2] = {1'b0, d2[3:0]};
                n_codes2[1] = {1'b0, d1[3:0]};
                n_codes2[0] = r_job1.neg ? GLYPH_MINUS : r_q3[CODE_W-1:0];
            end
        endcase

        o_frame       = r_frame;
        o_frame_valid = r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_job_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job1 <= i_job;
            r_q1   <= n_p1[47:32];
            r_q2   <= n_p2[47:32];
            r_q3   <= n_p3[47:32];
        end
        if (ready2 && r_v1) begin
            r_codes2 <= n_codes2;
        end
        if (ready3 && r_v2) begin
            r_frame <= render(r_codes2);
        end
    end

endmodule

// ===== sv/radix_number_dot_matrix_renderer_top.sv =====
// path: a transfer is queued, then held in the quotient, glyph code and output registers
// throughput: one item per cycle while m_axis_tready is high; the back pipeline
// (reciprocal multiply, digit extraction, glyph drawing) moves one item per stage, behind a 2-entry job queue
// reset: synchronous active low, empties queue and pipeline, number_base returns to 10
// depends on rndr_pkg, rndr_front, rndr_queue and rndr_back
module radix_number_dot_matrix_renderer_top import rndr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // value, glyph0, glyph1, glyph2, glyph3
    input  logic         s_axis_tuser,   // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // frame_word0, frame_word1, frame_word2
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic              REG_NUMBER_BASE = 1'b0;
    localparam logic [BASE_W-1:0] BASE_RESET      = BASE_W'(10);

    logic [BASE_W-1:0]  r_number_base;
    logic               cfg_write;
    logic               push;
    logic               queue_full;
    t_job               front_job;
    t_job               queue_job;
    logic               queue_valid;
    logic               pop;
    logic [FRAME_W-1:0] frame;

    always_comb begin
        pready    = 1'b1;
        cfg_write = psel && penable && pwrite && (paddr[2] == REG_NUMBER_BASE);
        prdata    = (paddr[2] == REG_NUMBER_BASE) ? {27'd0, r_number_base} : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (cfg_write) begin
            r_number_base <= pwdata[BASE_W-1:0];
        end
    end

    rndr_front u_front (
        .i_in_valid    (s_axis_tvalid),
        .i_in_user     (s_axis_tuser),
        .i_in_data     (s_axis_tdata),
        .o_in_ready    (s_axis_tready),
        .i_number_base (r_number_base),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    rndr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_valid (queue_valid)
    );

    rndr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (queue_job),
        .i_job_valid   (queue_valid),
        .o_job_pop     (pop),
        .o_frame       (frame),
        .o_frame_valid (m_axis_tvalid),
        .i_frame_ready (m_axis_tready)
    );

    // frame bit 95 is pixel index 0, which is bit 31 of frame_word0
    assign m_axis_tdata = {frame[31:0], frame[63:32], frame[95:64]};

endmodule
